// ===== hw/rtl/wtach_pkg.sv =====
// ----------------------------------------------------------------------------
// wtach_pkg
// Types, constants and codes shared by the windowed tachometer block.
// ----------------------------------------------------------------------------
package wtach_pkg;

  // parameter defaults
  localparam int COUNT_BITS_DEF = 24;
  localparam int TIME_BITS_DEF  = 48;
  localparam int FRAC_BITS_DEF  = 8;

  // result field widths
  localparam int TOTAL_W = 24;
  localparam int OUT_W   = 32;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int GAP_W      = 16;
  localparam int WIN_W      = 32;
  localparam int PPR_W      = 8;
  localparam int WEIGHT_W   = 17;

  localparam logic [GAP_W-1:0]    GAP_RST    = 16'd500;
  localparam logic [WIN_W-1:0]    WIN_RST    = 32'd1000000;
  localparam logic [PPR_W-1:0]    PPR_RST    = 8'd4;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 17'd19661;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

  // scale factors for rate (hertz) and rpm
  localparam int RATE_SCALE   = 1000000;
  localparam int RPM_SCALE    = 60000000;
  localparam int RPM_SCALE_W  = 26;

  // elapsed time is clipped to this many bits for the arithmetic
  localparam int ELAPSED_CAP_W = 56;

  // ema rounding and blend widths
  localparam int BLEND_W    = 49;
  localparam int ROUND_HALF = 32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAP    = 2'd0,
    CFG_WIN    = 2'd1,
    CFG_PPR    = 2'd2,
    CFG_WEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_POLL = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE,
    ST_POLL,
    ST_MUL,
    ST_RATE_GO,
    ST_RATE_WAIT,
    ST_RPM_GO,
    ST_RPM_WAIT,
    ST_BLEND_MUL,
    ST_BLEND_SUM,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [GAP_W-1:0]    gap;
    logic [WIN_W-1:0]    win;
    logic [PPR_W-1:0]    ppr;
    logic [WEIGHT_W-1:0] weight;
  } cfg_t;

  typedef struct packed {
    logic             done;
    logic [OUT_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hw/rtl/wtach_in_if.sv =====
// ----------------------------------------------------------------------------
// wtach_in_if
// Event request channel: opcode and timestamp with valid/ready.
// ----------------------------------------------------------------------------
interface wtach_in_if
  import wtach_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [TIME_BITS-1:0] stamp_us;

  modport source (output valid, opcode, stamp_us, input ready);
  modport sink   (input valid, opcode, stamp_us, output ready);
endinterface

// ===== hw/rtl/wtach_out_if.sv =====
// ----------------------------------------------------------------------------
// wtach_out_if
// Measurement request channel: window results with valid/ready.
// ----------------------------------------------------------------------------
interface wtach_out_if
  import wtach_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] pulse_total;
  logic [OUT_W-1:0]   pulse_rate_q8;
  logic [OUT_W-1:0]   rpm_raw_q8;
  logic [OUT_W-1:0]   rpm_smoothed_q8;
  logic [OUT_W-1:0]   elapsed_window_us;

  modport source (output valid, pulse_total, pulse_rate_q8, rpm_raw_q8,
                  rpm_smoothed_q8, elapsed_window_us, input ready);
  modport sink   (input valid, pulse_total, pulse_rate_q8, rpm_raw_q8,
                  rpm_smoothed_q8, elapsed_window_us, output ready);
endinterface

// ===== hw/rtl/wtach_cfg.sv =====
// ----------------------------------------------------------------------------
// wtach_cfg
// Configuration registers with write decode and operand clamping.
// ----------------------------------------------------------------------------
module wtach_cfg
  import wtach_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [CFG_IDX_W-1:0]  idx_i,
  input  logic [CFG_DATA_W-1:0] wdata_i,
  output cfg_t                  cfg_o
);

  logic [GAP_W-1:0]    gap_q;
  logic [WIN_W-1:0]    win_q;
  logic [PPR_W-1:0]    ppr_q;
  logic [WEIGHT_W-1:0] weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q    <= GAP_RST;
      win_q    <= WIN_RST;
      ppr_q    <= PPR_RST;
      weight_q <= WEIGHT_RST;
    end else if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CFG_GAP:    gap_q    <= wdata_i[GAP_W-1:0];
        CFG_WIN:    win_q    <= wdata_i[WIN_W-1:0];
        CFG_PPR:    ppr_q    <= wdata_i[PPR_W-1:0];
        CFG_WEIGHT: weight_q <= wdata_i[WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero pulses per rev acts as one, weight above one acts as one
  always_comb begin
    cfg_o.gap    = gap_q;
    cfg_o.win    = win_q;
    cfg_o.ppr    = (ppr_q == '0) ? PPR_W'(1) : ppr_q;
    cfg_o.weight = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
  end

endmodule

// ===== hw/rtl/wtach_div.sv =====
// ----------------------------------------------------------------------------
// wtach_div
// Shared restoring divider, one quotient bit per cycle, saturating quotient.
// ----------------------------------------------------------------------------
module wtach_div
  import wtach_pkg::*;
#(
  parameter int NUM_W = 58,
  parameter int DEN_W = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output div_rsp_t         rsp_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [OUT_W-1:0] quo_q, quo_d;
  logic             ovf_q, ovf_d;

  logic [DEN_W:0]   rem_sh;
  logic             fit;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign fit    = (rem_sh >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      ovf_d  = 1'b0;
    end else if (busy_q) begin
      rem_d = fit ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      quo_d = {quo_q[OUT_W-2:0], fit};
      ovf_d = ovf_q | quo_q[OUT_W-1];
      num_d = num_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  always_comb begin
    rsp_o.done = done_q;
    if (den_q == '0) begin
      rsp_o.quot = '0;
    end else if (ovf_q) begin
      rsp_o.quot = '1;
    end else begin
      rsp_o.quot = quo_q;
    end
  end

endmodule

// ===== hw/rtl/windowed_tachometer_ema_top.sv =====
// ----------------------------------------------------------------------------
// windowed_tachometer_ema_top
// Gated-window tachometer with debounced pulse counting and ema smoothing.
// ----------------------------------------------------------------------------
// A pulse edge or a poll that does not close the window passes through its
// sequencer state (ST_EDGE or ST_POLL) and back to idle before the next request
// can be taken. A poll that closes the window runs two divisions on one shared
// bit-serial divider, one quotient step per cycle over NUM_W = COUNT_BITS +
// FRAC_BITS + 26 numerator bits. The result sits in an output register; a new
// request is taken while it waits, and a second closing poll stalls only at its
// final step until the earlier result is taken. Rate and rpm outputs are unsigned
// Q.FRAC_BITS; all outputs saturate.
// ----------------------------------------------------------------------------
module windowed_tachometer_ema_top
  import wtach_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  wtach_in_if.sink              evt_i,
  wtach_out_if.source           meas_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int E_W   = (TIME_BITS > ELAPSED_CAP_W) ? ELAPSED_CAP_W : TIME_BITS;
  localparam int DEN_W = E_W + PPR_W;
  localparam int NUM_W = COUNT_BITS + RPM_SCALE_W + FRAC_BITS;

  cfg_t     cfg;
  div_rsp_t div_rsp;
  logic     div_start;
  logic     div_sel_rpm;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;

  state_e state_q, state_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [TIME_BITS-1:0]  last_q, last_d;
  logic                  seen_q, seen_d;
  logic [TIME_BITS-1:0]  wstart_q, wstart_d;
  logic [OUT_W-1:0]      smooth_q, smooth_d;
  logic                  first_q, first_d;
  logic                  out_valid_q, out_valid_d;

  logic [TIME_BITS-1:0]  ts_q, ts_d;
  logic [TIME_BITS-1:0]  elapsed_q, elapsed_d;
  logic [E_W-1:0]        e_q, e_d;
  logic [NUM_W-1:0]      num_rate_q, num_rate_d;
  logic [NUM_W-1:0]      num_rpm_q, num_rpm_d;
  logic [DEN_W-1:0]      den_rpm_q, den_rpm_d;
  logic [OUT_W-1:0]      rate_q, rate_d;
  logic [OUT_W-1:0]      raw_q, raw_d;
  logic [BLEND_W-1:0]    p_new_q, p_new_d;
  logic [BLEND_W-1:0]    p_old_q, p_old_d;
  logic [OUT_W-1:0]      smooth_nxt_q, smooth_nxt_d;
  logic [TOTAL_W-1:0]    total_q, total_d;
  logic [OUT_W-1:0]      rate_o_q, rate_o_d;
  logic [OUT_W-1:0]      raw_o_q, raw_o_d;
  logic [OUT_W-1:0]      smooth_o_q, smooth_o_d;
  logic [OUT_W-1:0]      elapsed_o_q, elapsed_o_d;

  logic [TIME_BITS-1:0]  since_edge;
  logic [TIME_BITS-1:0]  elapsed_now;
  logic [BLEND_W-1:0]    blend_sum;

  wtach_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  assign div_num = div_sel_rpm ? num_rpm_q : num_rate_q;
  assign div_den = div_sel_rpm ? den_rpm_q : DEN_W'(e_q);

  wtach_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .rsp_o   (div_rsp)
  );

  // saturating time differences
  assign since_edge  = (ts_q >= last_q)   ? (ts_q - last_q)   : '0;
  assign elapsed_now = (ts_q >= wstart_q) ? (ts_q - wstart_q) : '0;
  assign blend_sum   = p_new_q + p_old_q + BLEND_W'(ROUND_HALF);

  assign evt_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    last_d       = last_q;
    seen_d       = seen_q;
    wstart_d     = wstart_q;
    smooth_d     = smooth_q;
    first_d      = first_q;
    out_valid_d  = out_valid_q && !meas_o.ready;
    ts_d         = ts_q;
    elapsed_d    = elapsed_q;
    e_d          = e_q;
    num_rate_d   = num_rate_q;
    num_rpm_d    = num_rpm_q;
    den_rpm_d    = den_rpm_q;
    rate_d       = rate_q;
    raw_d        = raw_q;
    p_new_d      = p_new_q;
    p_old_d      = p_old_q;
    smooth_nxt_d = smooth_nxt_q;
    total_d      = total_q;
    rate_o_d     = rate_o_q;
    raw_o_d      = raw_o_q;
    smooth_o_d   = smooth_o_q;
    elapsed_o_d  = elapsed_o_q;
    div_start    = 1'b0;
    div_sel_rpm  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (evt_i.valid) begin
          ts_d    = evt_i.stamp_us;
          state_d = (op_e'(evt_i.opcode) == OP_POLL) ? ST_POLL : ST_EDGE;
        end
      end
      ST_EDGE: begin
        if (!seen_q || (since_edge >= TIME_BITS'(cfg.gap))) begin
          if (cnt_q != '1) begin
            cnt_d = cnt_q + 1'b1;
          end
          last_d = ts_q;
          seen_d = 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_POLL: begin
        elapsed_d = elapsed_now;
        e_d       = ((elapsed_now >> E_W) != '0) ? '1 : E_W'(elapsed_now);
        state_d   = (elapsed_now >= TIME_BITS'(cfg.win)) ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        num_rate_d = (NUM_W'(cnt_q) * NUM_W'(RATE_SCALE)) << FRAC_BITS;
        num_rpm_d  = (NUM_W'(cnt_q) * NUM_W'(RPM_SCALE)) << FRAC_BITS;
        den_rpm_d  = DEN_W'(e_q) * DEN_W'(cfg.ppr);
        state_d    = ST_RATE_GO;
      end
      ST_RATE_GO: begin
        div_start = 1'b1;
        state_d   = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        if (div_rsp.done) begin
          rate_d  = div_rsp.quot;
          state_d = ST_RPM_GO;
        end
      end
      ST_RPM_GO: begin
        div_start   = 1'b1;
        div_sel_rpm = 1'b1;
        state_d     = ST_RPM_WAIT;
      end
      ST_RPM_WAIT: begin
        if (div_rsp.done) begin
          raw_d   = div_rsp.quot;
          state_d = ST_BLEND_MUL;
        end
      end
      ST_BLEND_MUL: begin
        p_new_d = BLEND_W'(cfg.weight) * BLEND_W'(raw_q);
        p_old_d = BLEND_W'(WEIGHT_ONE - cfg.weight) * BLEND_W'(smooth_q);
        state_d = ST_BLEND_SUM;
      end
      ST_BLEND_SUM: begin
        // first window loads the filter directly
        smooth_nxt_d = first_q ? raw_q : blend_sum[47:16];
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || meas_o.ready) begin
          out_valid_d = 1'b1;
          total_d     = ((cnt_q >> TOTAL_W) != '0) ? '1 : TOTAL_W'(cnt_q);
          rate_o_d    = rate_q;
          raw_o_d     = raw_q;
          smooth_o_d  = smooth_nxt_q;
          elapsed_o_d = ((elapsed_q >> OUT_W) != '0) ? '1 : OUT_W'(elapsed_q);
          smooth_d    = smooth_nxt_q;
          first_d     = 1'b0;
          cnt_d       = '0;
          wstart_d    = ts_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      last_q      <= '0;
      seen_q      <= 1'b0;
      wstart_q    <= '0;
      smooth_q    <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      seen_q      <= seen_d;
      wstart_q    <= wstart_d;
      smooth_q    <= smooth_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ts_q         <= ts_d;
    elapsed_q    <= elapsed_d;
    e_q          <= e_d;
    num_rate_q   <= num_rate_d;
    num_rpm_q    <= num_rpm_d;
    den_rpm_q    <= den_rpm_d;
    rate_q       <= rate_d;
    raw_q        <= raw_d;
    p_new_q      <= p_new_d;
    p_old_q      <= p_old_d;
    smooth_nxt_q <= smooth_nxt_d;
    total_q      <= total_d;
    rate_o_q     <= rate_o_d;
    raw_o_q      <= raw_o_d;
    smooth_o_q   <= smooth_o_d;
    elapsed_o_q  <= elapsed_o_d;
  end

  assign meas_o.valid             = out_valid_q;
  assign meas_o.pulse_total       = total_q;
  assign meas_o.pulse_rate_q8     = rate_o_q;
  assign meas_o.rpm_raw_q8        = raw_o_q;
  assign meas_o.rpm_smoothed_q8   = smooth_o_q;
  assign meas_o.elapsed_window_us = elapsed_o_q;

`ifndef NO_ASSERTIONS
  // a new result restarts the window
  a_window_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (cnt_q == '0) && !first_q)
    else $error("window not restarted with result");

  // divider completes only while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_RATE_WAIT) || (state_q == ST_RPM_WAIT))
    else $error("divider done outside wait state");

  // an empty window reports zero rate and rpm
  a_empty_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (total_q != '0) || ((rate_o_q == '0) && (raw_o_q == '0)))
    else $error("nonzero rate for empty window");

  // results only come out of the final step
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result without sequencer");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the windowed tachometer: a directed table of pulse
// edges and polls, then randomized phases under several register settings.
// Every closing poll is predicted at acceptance and compared in order with
// the measurement stream, under random gaps, stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import wtach_pkg::*;

  localparam int TS_W            = TIME_BITS_DEF;
  localparam int CNT_W           = COUNT_BITS_DEF;
  localparam int N_PHASES        = 6;
  localparam int HOLD_PHASE      = 2;
  localparam int ITEMS_PER_PHASE = 220;
  localparam int BURST_LEN       = 20;
  localparam int HOLD_CYCLES     = 800;
  localparam int CFG_SETTLE      = 16;
  localparam int END_SETTLE      = 200;
  localparam int STUCK_LIMIT     = 5000;
  localparam int MAX_REPORTS     = 10;
  localparam logic [63:0] ELAPSED_LIM = (64'd1 << ELAPSED_CAP_W) - 64'd1;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [OUT_W-1:0]   rate;
    logic [OUT_W-1:0]   raw;
    logic [OUT_W-1:0]   smooth;
    logic [OUT_W-1:0]   elapsed;
  } meas_t;

  typedef enum logic {
    ROW_EVT,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    op_e                   op;
    logic [TS_W-1:0]       ts;
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  typed;
    meas_t                 res;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wtach_in_if #(.TIME_BITS(TS_W)) evt_if ();
  wtach_out_if meas_if ();

  windowed_tachometer_ema_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .evt_i       (evt_if.sink),
    .meas_o      (meas_if.source),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tachometer shadow state and register copy
  cfg_t              cfg_shadow   = '{GAP_RST, WIN_RST, PPR_RST, WEIGHT_RST};
  logic [CNT_W-1:0]  pulse_cnt    = '0;
  logic [TS_W-1:0]   last_edge_ts = '0;
  logic              edge_valid   = 1'b0;
  logic [TS_W-1:0]   win_start_ts = '0;
  logic [OUT_W-1:0]  ema_rpm      = '0;
  logic              first_win    = 1'b1;

  meas_t             meas_expected[$];
  int                mismatches   = 0;
  bit                hold_request = 1'b0;
  logic [TS_W-1:0]   ts_now       = 48'h8000_0000_0000;

  // floor(num * 2^FRAC / den), all ones on overflow, zero for a zero divisor
  function automatic logic [OUT_W-1:0] q8_ratio(logic [63:0] num, logic [63:0] den);
    logic [63:0]      quo;
    logic [63:0]      rem;
    logic [OUT_W-1:0] frac;
    frac = '0;
    if (den == 64'd0) return '0;
    quo = num / den;
    rem = num % den;
    if (quo > (64'hFFFF_FFFF >> FRAC_BITS_DEF)) return '1;
    for (int i = 0; i < FRAC_BITS_DEF; i++) begin
      frac = frac << 1;
      if (rem >= den - rem) begin
        rem     = rem - (den - rem);
        frac[0] = 1'b1;
      end else begin
        rem = rem + rem;
      end
    end
    return OUT_W'((quo << FRAC_BITS_DEF) | 64'(frac));
  endfunction

  function automatic bit tach_update(input op_e op, input logic [TS_W-1:0] ts,
                                     output meas_t res);
    logic [63:0]      dt;
    logic [63:0]      elapsed;
    logic [63:0]      e;
    logic [63:0]      ppr;
    logic [63:0]      w;
    logic [63:0]      blended;
    logic [OUT_W-1:0] rate;
    logic [OUT_W-1:0] raw;
    res = '0;
    if (op == OP_EDGE) begin
      dt = (ts >= last_edge_ts) ? 64'(ts - last_edge_ts) : 64'd0;
      if (!edge_valid || dt >= 64'(cfg_shadow.gap)) begin
        if (pulse_cnt != '1) pulse_cnt = pulse_cnt + 1'b1;
        last_edge_ts = ts;
        edge_valid   = 1'b1;
      end
      return 1'b0;
    end
    elapsed = (ts >= win_start_ts) ? 64'(ts - win_start_ts) : 64'd0;
    if (elapsed < 64'(cfg_shadow.win)) return 1'b0;
    e    = (elapsed > ELAPSED_LIM) ? ELAPSED_LIM : elapsed;
    ppr  = (cfg_shadow.ppr == '0) ? 64'd1 : 64'(cfg_shadow.ppr);
    rate = q8_ratio(64'(pulse_cnt) * 64'(RATE_SCALE), e);
    raw  = q8_ratio(64'(pulse_cnt) * 64'(RPM_SCALE), e * ppr);
    if (first_win) begin
      ema_rpm   = raw;
      first_win = 1'b0;
    end else begin
      w = (cfg_shadow.weight > WEIGHT_ONE) ? 64'(WEIGHT_ONE) : 64'(cfg_shadow.weight);
      blended = w * 64'(raw) + (64'd65536 - w) * 64'(ema_rpm) + 64'(ROUND_HALF);
      ema_rpm = blended[47:16];
    end
    res.total   = TOTAL_W'(pulse_cnt);
    res.rate    = rate;
    res.raw     = raw;
    res.smooth  = ema_rpm;
    res.elapsed = (elapsed > 64'hFFFF_FFFF) ? '1 : elapsed[31:0];
    pulse_cnt    = '0;
    win_start_ts = ts;
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic row_t evt_row(op_e op, logic [TS_W-1:0] ts);
    row_t r;
    r      = '0;
    r.kind = ROW_EVT;
    r.op   = op;
    r.ts   = ts;
    return r;
  endfunction

  function automatic row_t chk_row(op_e op, logic [TS_W-1:0] ts, meas_t res);
    row_t r;
    r       = evt_row(op, ts);
    r.typed = 1'b1;
    r.res   = res;
    return r;
  endfunction

  function automatic row_t reg_row(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  task automatic report_mismatch(string what, meas_t want, meas_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] %s exp/act: total %0d/%0d rate %h/%h raw %h/%h", $time, what,
               want.total, got.total, want.rate, got.rate, want.raw, got.raw);
      $display("    ema %h/%h elapsed %0d/%0d",
               want.smooth, got.smooth, want.elapsed, got.elapsed);
    end
  endtask

  task automatic send_event(input op_e op, input logic [TS_W-1:0] ts,
                            input logic typed, input meas_t typed_res);
    int unsigned gap;
    meas_t       res;
    gap = pick_gap();
    if (gap != 0) begin
      evt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt_if.valid    <= 1'b1;
    evt_if.opcode   <= op;
    evt_if.stamp_us <= ts;
    @(posedge clk);
    while (!evt_if.ready) @(posedge clk);
    if (tach_update(op, ts, res)) begin
      if (typed) res = typed_res;
      meas_expected.push_back(res);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_GAP:    cfg_shadow.gap    = data[GAP_W-1:0];
      CFG_WIN:    cfg_shadow.win    = data[WIN_W-1:0];
      CFG_PPR:    cfg_shadow.ppr    = data[PPR_W-1:0];
      CFG_WEIGHT: cfg_shadow.weight = data[WEIGHT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain_results();
    evt_if.valid <= 1'b0;
    while (meas_expected.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  // measurement checker
  always @(posedge clk) begin : meas_check
    meas_t got;
    meas_t want;
    if (rst_n && meas_if.valid && meas_if.ready) begin
      got.total   = meas_if.pulse_total;
      got.rate    = meas_if.pulse_rate_q8;
      got.raw     = meas_if.rpm_raw_q8;
      got.smooth  = meas_if.rpm_smoothed_q8;
      got.elapsed = meas_if.elapsed_window_us;
      if (meas_expected.size() == 0) begin
        report_mismatch("unexpected", '0, got);
      end else begin
        want = meas_expected.pop_front();
        if (got.total != want.total || got.rate != want.rate || got.raw != want.raw ||
            got.smooth != want.smooth || got.elapsed != want.elapsed) begin
          report_mismatch("mismatch", want, got);
        end
      end
    end
  end

  // progress watchdog
  always @(posedge clk) begin : stuck_watch
    int stuck_cycles;
    if (rst_n) begin
      if ((evt_if.valid && evt_if.ready) || (meas_if.valid && meas_if.ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("[%0t] no request moved for %0d cycles", $time, stuck_cycles);
        $display("Some tests failed");
        $finish;
      end
    end else begin
      stuck_cycles = 0;
    end
  end

  // measurement receiver
  initial begin : meas_sink
    int unsigned r;
    int unsigned n;
    meas_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        meas_if.ready <= 1'b0;
        n = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          meas_if.ready <= 1'b1;
          n = $urandom_range(1, 40);
        end else begin
          meas_if.ready <= 1'b0;
          if (r < 90) n = $urandom_range(1, 3);
          else if (r < 97) n = $urandom_range(4, 12);
          else n = $urandom_range(20, 60);
        end
      end
      repeat (n) @(posedge clk);
    end
  end

  initial begin : stimulus
    row_t            dir_rows[$];
    cfg_t            c;
    int unsigned     sel;
    int unsigned     r;
    int unsigned     step;
    int unsigned     back;
    logic [TS_W-1:0] ts;

    rst_n           = 1'b0;
    evt_if.valid    = 1'b0;
    evt_if.opcode   = OP_EDGE;
    evt_if.stamp_us = '0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_GAP;
    cfg_wdata       = '0;

    // reset settings, debounce and first window
    dir_rows.push_back(evt_row(OP_EDGE, 48'd0));
    dir_rows.push_back(evt_row(OP_EDGE, 48'd100));
    dir_rows.push_back(evt_row(OP_EDGE, 48'd600));
    dir_rows.push_back(evt_row(OP_EDGE, 48'd1100));
    dir_rows.push_back(evt_row(OP_POLL, 48'd999999));
    dir_rows.push_back(chk_row(OP_POLL, 48'd1000000,
                               meas_t'{24'd3, 32'd768, 32'd11520, 32'd11520, 32'd1000000}));
    // time going backwards
    dir_rows.push_back(evt_row(OP_EDGE, 48'd1000050));
    dir_rows.push_back(evt_row(OP_EDGE, 48'd900));
    dir_rows.push_back(evt_row(OP_POLL, 48'd5));
    // zero window, zero ppr, full weight
    dir_rows.push_back(reg_row(CFG_GAP, 32'd0));
    dir_rows.push_back(reg_row(CFG_WIN, 32'd0));
    dir_rows.push_back(reg_row(CFG_PPR, 32'd0));
    dir_rows.push_back(reg_row(CFG_WEIGHT, 32'd65536));
    dir_rows.push_back(evt_row(OP_EDGE, 48'd1000050));
    dir_rows.push_back(chk_row(OP_POLL, 48'd1000000, meas_t'{24'd2, 32'd0, 32'd0, 32'd0, 32'd0}));
    dir_rows.push_back(evt_row(OP_EDGE, 48'd1000000));
    dir_rows.push_back(chk_row(OP_POLL, 48'd1000001,
                               meas_t'{24'd1, 32'd256000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       32'd1}));
    // largest registers, weight above one, huge elapsed
    dir_rows.push_back(reg_row(CFG_GAP, 32'h5A5A_FFFF));
    dir_rows.push_back(reg_row(CFG_WIN, 32'hFFFF_FFFF));
    dir_rows.push_back(reg_row(CFG_PPR, 32'hA5A5_A5FF));
    dir_rows.push_back(reg_row(CFG_WEIGHT, 32'hFFFF_FFFF));
    dir_rows.push_back(evt_row(OP_EDGE, 48'd1065535));
    dir_rows.push_back(evt_row(OP_EDGE, 48'd1100000));
    dir_rows.push_back(evt_row(OP_POLL, 48'd4295967295));
    dir_rows.push_back(evt_row(OP_POLL, 48'd4295967296));
    dir_rows.push_back(chk_row(OP_POLL, 48'h8000_0000_0000,
                               meas_t'{24'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF}));
    dir_rows.push_back(evt_row(OP_EDGE, 48'h8000_0000_0000));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (i == 0 || dir_rows[i-1].kind != ROW_CFG) drain_results();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
        if (i + 1 == dir_rows.size() || dir_rows[i+1].kind != ROW_CFG) cfg_we <= 1'b0;
      end else begin
        send_event(dir_rows[i].op, dir_rows[i].ts, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: c = '{16'd0, 32'd0, 8'd0, 17'd0};
        1: c = '{16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 17'h1FFFF};
        default: begin
          sel = $urandom_range(0, 9);
          if (sel == 0) c.win = 32'd0;
          else if (sel == 1) c.win = 32'd1;
          else if (sel == 2) c.win = 32'hFFFF_FFFF;
          else c.win = $urandom_range(200, 20000);
          if (ph == HOLD_PHASE) c.win = $urandom_range(1, 50);
          sel = $urandom_range(0, 5);
          if (sel == 0) c.gap = 16'd0;
          else if (sel == 1) c.gap = 16'hFFFF;
          else c.gap = $urandom_range(0, 200);
          sel = $urandom_range(0, 5);
          if (sel == 0) c.ppr = 8'd0;
          else if (sel == 1) c.ppr = 8'd1;
          else if (sel == 2) c.ppr = 8'hFF;
          else c.ppr = $urandom_range(1, 254);
          sel = $urandom_range(0, 5);
          if (sel == 0) c.weight = 17'd0;
          else if (sel == 1) c.weight = WEIGHT_ONE;
          else if (sel == 2) c.weight = 17'h1FFFF;
          else c.weight = $urandom_range(0, 65536);
        end
      endcase
      write_reg(CFG_GAP, (32'($urandom) & 32'hFFFF_0000) | 32'(c.gap));
      write_reg(CFG_WIN, 32'(c.win));
      write_reg(CFG_PPR, (32'($urandom) & 32'hFFFF_FF00) | 32'(c.ppr));
      write_reg(CFG_WEIGHT, (32'($urandom) & 32'hFFFE_0000) | 32'(c.weight));
      cfg_we <= 1'b0;
      if (ph == HOLD_PHASE) hold_request = 1'b1;

      if (c.win == 32'd0) step = 3;
      else if (c.win > 32'h4000_0000) step = c.win / 5;
      else step = c.win / 6 + 1;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          // stale timestamp
          back = $urandom_range(0, step);
          ts   = (ts_now > TS_W'(back)) ? ts_now - TS_W'(back) : '0;
          send_event(op_e'($urandom_range(0, 1)), ts, 1'b0, '0);
        end else if (r == 3) begin
          // burst of edges at one instant
          repeat (BURST_LEN) send_event(OP_EDGE, ts_now, 1'b0, '0);
        end else begin
          ts_now = ts_now + TS_W'($urandom_range(0, step));
          send_event(($urandom_range(0, 99) < 22) ? OP_POLL : OP_EDGE, ts_now, 1'b0, '0);
        end
      end
    end

    send_event(OP_POLL, 48'hFFFF_FFFF_FFFF, 1'b0, '0);
    drain_results();
    repeat (END_SETTLE) @(posedge clk);

    if (mismatches == 0 && meas_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
